// ----- design/tdlp_pkg.sv -----
package tdlp_pkg;

    localparam int COLUMNS   = 120;
    localparam int BANDS     = 8;
    localparam int LANES     = 8;
    localparam int POSITIONS = COLUMNS * BANDS;
    localparam int POS_W     = $clog2(POSITIONS);

    localparam logic [7:0] DECAY_RESET = 8'd3;
    localparam logic [7:0] LEVEL_MAX   = 8'd255;

    typedef logic [POS_W-1:0] pos_t;

    // Control shared by every lane RAM
    typedef struct packed {
        logic rd_en;
        pos_t rd_addr;
        logic wr_en;
        logic wr_zero;
        pos_t wr_addr;
    } lane_ctrl_t;

endpackage

// ----- design/tdlp_ram.sv -----
module tdlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 960
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/tdlp_lane.sv -----
module tdlp_lane (
    input  logic                clk,
    input  tdlp_pkg::lane_ctrl_t ctrl,
    input  logic [7:0]          pixel,
    input  logic [7:0]          decay,
    output logic                lit
);

    import tdlp_pkg::*;

    logic [7:0]  pixel_reg;
    logic [7:0]  level;
    logic [8:0]  leak_gain;
    logic [16:0] product;
    logic [8:0]  leaked;
    logic [9:0]  charged;
    logic [7:0]  level_next;
    logic [7:0]  wdata;

    tdlp_ram #(
        .WIDTH (8),
        .DEPTH (POSITIONS)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.wr_en),
        .waddr (ctrl.wr_addr),
        .wdata (wdata),
        .re    (ctrl.rd_en),
        .raddr (ctrl.rd_addr),
        .rdata (level)
    );

    // Hold the pixel next to the intensity being read for it
    always_ff @(posedge clk)
    begin
        if (ctrl.rd_en)
        begin
            pixel_reg <= pixel;
        end
    end

    always_comb
    begin
        lit       = (level < pixel_reg);
        leak_gain = 9'd256 - {1'b0, decay};
        product   = 17'(level * leak_gain);
        leaked    = product[16:8];
        charged   = {1'b0, leaked} + (lit ? {2'b00, decay} : 10'd0);
        level_next = (charged > {2'b00, LEVEL_MAX}) ? LEVEL_MAX : charged[7:0];
        wdata     = ctrl.wr_zero ? 8'd0 : level_next;
    end

endmodule

// ----- design/tdlp_pack.sv -----
module tdlp_pack (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load,
    input  logic [tdlp_pkg::LANES-1:0]    lits,
    input  logic                          last,
    input  logic                          byte_stall,
    output logic                          advance,
    output logic                          byte_valid,
    output logic [7:0]                    lcd_byte,
    output logic                          frame_end
);

    import tdlp_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       end_reg;

    assign advance = !valid_reg || !byte_stall;

    always_comb
    begin
        priority if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Row k lands at bit k
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= 8'(lits);
            end_reg  <= last;
        end
    end

    assign byte_valid = valid_reg;
    assign lcd_byte   = byte_reg;
    assign frame_end  = end_reg;

endmodule

// ----- design/temporal_dither_lcd_packer.sv -----
// Temporal 1-bit dither packer: each transfer carries eight gray pixels of one
// column in an 8-row band and yields one LCD byte, bit k lit when the stored
// intensity of row k is below its pixel. One item per cycle is sustained while
// byte_stall is low and no clear runs; a taken item passes the intensity RAM
// read, then compare/update and write-back into the output register. Each of
// the eight lanes owns one 960x8 intensity RAM with one read and one write port.
// After reset the RAMs are zeroed one address per cycle, so pixel_stall stays
// high until all 960 addresses are cleared; decay writes are taken at any time.
module temporal_dither_lcd_packer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       pixel_valid,
    output logic       pixel_stall,
    input  logic [7:0] pixel_row0,
    input  logic [7:0] pixel_row1,
    input  logic [7:0] pixel_row2,
    input  logic [7:0] pixel_row3,
    input  logic [7:0] pixel_row4,
    input  logic [7:0] pixel_row5,
    input  logic [7:0] pixel_row6,
    input  logic [7:0] pixel_row7,
    output logic       byte_valid,
    input  logic       byte_stall,
    output logic [7:0] lcd_byte,
    output logic       frame_end,
    input  logic       decay_valid,
    output logic       decay_ready,
    input  logic [7:0] decay
);

    import tdlp_pkg::*;

    logic              accept;
    logic              advance;
    logic              write_back;
    logic [7:0]        decay_reg;
    pos_t              pos_reg;
    pos_t              pos_next;
    logic              clearing_reg;
    logic              clearing_next;
    pos_t              clear_addr_reg;
    pos_t              clear_addr_next;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    pos_t              s1_addr_reg;
    logic              s1_last_reg;
    logic              pos_last;
    lane_ctrl_t        ctrl;
    logic [7:0]        pixel_lane [LANES];
    logic [LANES-1:0]  lits;

    assign pixel_lane[0] = pixel_row0;
    assign pixel_lane[1] = pixel_row1;
    assign pixel_lane[2] = pixel_row2;
    assign pixel_lane[3] = pixel_row3;
    assign pixel_lane[4] = pixel_row4;
    assign pixel_lane[5] = pixel_row5;
    assign pixel_lane[6] = pixel_row6;
    assign pixel_lane[7] = pixel_row7;

    assign decay_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= DECAY_RESET;
        end
        else if (decay_valid && decay_ready)
        begin
            decay_reg <= decay;
        end
    end

    assign pixel_stall = clearing_reg || (s1_valid_reg && !advance);
    assign accept      = pixel_valid && !pixel_stall;
    assign write_back  = s1_valid_reg && advance;
    assign pos_last    = (pos_reg == pos_t'(POSITIONS - 1));

    always_comb
    begin
        pos_next        = pos_reg;
        clearing_next   = clearing_reg;
        clear_addr_next = clear_addr_reg;
        if (accept)
        begin
            pos_next = pos_last ? '0 : pos_t'(pos_reg + 1'b1);
        end
        if (clearing_reg)
        begin
            if (clear_addr_reg == pos_t'(POSITIONS - 1))
            begin
                clearing_next = 1'b0;
            end
            clear_addr_next = pos_t'(clear_addr_reg + 1'b1);
        end
        priority if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            pos_reg        <= pos_next;
            clearing_reg   <= clearing_next;
            clear_addr_reg <= clear_addr_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_addr_reg <= pos_reg;
            s1_last_reg <= pos_last;
        end
    end

    always_comb
    begin
        ctrl.rd_en   = accept;
        ctrl.rd_addr = pos_reg;
        ctrl.wr_en   = clearing_reg || write_back;
        ctrl.wr_zero = clearing_reg;
        ctrl.wr_addr = clearing_reg ? clear_addr_reg : s1_addr_reg;
    end

    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        tdlp_lane u_lane (
            .clk   (clk),
            .ctrl  (ctrl),
            .pixel (pixel_lane[k]),
            .decay (decay_reg),
            .lit   (lits[k])
        );
    end

    tdlp_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (write_back),
        .lits       (lits),
        .last       (s1_last_reg),
        .byte_stall (byte_stall),
        .advance    (advance),
        .byte_valid (byte_valid),
        .lcd_byte   (lcd_byte),
        .frame_end  (frame_end)
    );

endmodule

// ----- design/tdlp_checker.sv -----
module tdlp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pixel_valid,
    input logic       pixel_stall,
    input logic       byte_valid,
    input logic       byte_stall,
    input logic [7:0] lcd_byte,
    input logic       frame_end,
    input logic       decay_valid,
    input logic       decay_ready
);

    import tdlp_pkg::*;

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    pos_t       out_pos_reg;
    pos_t       out_pos_next;

    assign in_xfer  = pixel_valid && !pixel_stall;
    assign out_xfer = byte_valid && !byte_stall;

    always_comb
    begin
        inflight_next = 2'(inflight_reg + {1'b0, in_xfer} - {1'b0, out_xfer});
        out_pos_next  = out_pos_reg;
        if (out_xfer)
        begin
            out_pos_next = (out_pos_reg == pos_t'(POSITIONS - 1)) ? '0
                                                                 : pos_t'(out_pos_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
            out_pos_reg  <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
            out_pos_reg  <= out_pos_next;
        end
    end

    // Frame end marks exactly every last byte of a frame
    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> (frame_end == (out_pos_reg == pos_t'(POSITIONS - 1))))
        else $error("frame_end out of step with delivered byte count");

    // Two pipeline slots at most
    a_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more items in flight than pipeline slots");

    // A fresh result follows an input transfer through the RAM read and write-back registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(byte_valid) |-> $past(in_xfer, 2))
        else $error("result appeared without a matching input transfer");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        byte_valid && byte_stall |=> byte_valid && $stable(lcd_byte) && $stable(frame_end))
        else $error("stalled result changed");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        decay_valid |-> decay_ready)
        else $error("decay write refused");

endmodule

bind temporal_dither_lcd_packer tdlp_checker u_checker (.*);
